### sv/ctt_pkg.sv
// Shared types and constants of the CIF text tokenizer.
`timescale 1ns / 1ps
`default_nettype none

package ctt_pkg;

   // Lexer modes.
   typedef enum logic [3:0] {
      MODE_BOM0    = 4'd0,
      MODE_BOM1    = 4'd1,
      MODE_BOM2    = 4'd2,
      MODE_IDLE    = 4'd3,
      MODE_COMMENT = 4'd4,
      MODE_WORD    = 4'd5,
      MODE_Q1      = 4'd6,
      MODE_Q2      = 4'd7,
      MODE_QUOTED  = 4'd8,
      MODE_TRIPLE  = 4'd9,
      MODE_FIELD   = 4'd10,
      MODE_DONE    = 4'd11
   } mode_type;

   // Token kinds.
   localparam logic [3:0] KIND_VALUE    = 4'd0;
   localparam logic [3:0] KIND_TAG      = 4'd1;
   localparam logic [3:0] KIND_BLOCK    = 4'd2;
   localparam logic [3:0] KIND_LOOP     = 4'd3;
   localparam logic [3:0] KIND_SAVE_END = 4'd4;
   localparam logic [3:0] KIND_SAVE_HDR = 4'd5;
   localparam logic [3:0] KIND_EOF      = 4'd6;
   localparam logic [3:0] KIND_QERR     = 4'd7;
   localparam logic [3:0] KIND_FERR     = 4'd8;

   // Commands.
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_END  = 1'b1;

   // Keyword flag bit positions.
   localparam int FLAG_TAG    = 0;
   localparam int FLAG_DATA   = 1;
   localparam int FLAG_GLOBAL = 2;
   localparam int FLAG_LOOP   = 3;
   localparam int FLAG_SAVE   = 4;

   // Keyword selectors.
   localparam logic [1:0] KW_DATA   = 2'd0;
   localparam logic [1:0] KW_GLOBAL = 2'd1;
   localparam logic [1:0] KW_LOOP   = 2'd2;
   localparam logic [1:0] KW_SAVE   = 2'd3;

   // Special bytes.
   localparam logic [7:0] BYTE_BOM0 = 8'hEF;
   localparam logic [7:0] BYTE_BOM1 = 8'hBB;
   localparam logic [7:0] BYTE_BOM2 = 8'hBF;
   localparam logic [7:0] BYTE_EOF  = 8'h1A;

   // One result beat.
   typedef struct packed {
      logic [3:0]  token_kind;
      logic [31:0] start_offset;
      logic [31:0] content_length;
      logic [31:0] start_line;
      logic [31:0] start_column;
      logic        last_in_run;
   } result_type;

   // Lowercase character of a keyword at a position; zero past its end.
   function automatic logic [7:0] kw_char(input logic [1:0] sel, input logic [2:0] idx);
      logic [7:0] c;
      c = 8'h00;
      case (sel)
         KW_DATA: begin
            case (idx)
               3'd0: c = "d";
               3'd1: c = "a";
               3'd2: c = "t";
               3'd3: c = "a";
               3'd4: c = "_";
               default: c = 8'h00;
            endcase
         end
         KW_GLOBAL: begin
            case (idx)
               3'd0: c = "g";
               3'd1: c = "l";
               3'd2: c = "o";
               3'd3: c = "b";
               3'd4: c = "a";
               3'd5: c = "l";
               3'd6: c = "_";
               default: c = 8'h00;
            endcase
         end
         KW_LOOP: begin
            case (idx)
               3'd0: c = "l";
               3'd1: c = "o";
               3'd2: c = "o";
               3'd3: c = "p";
               3'd4: c = "_";
               default: c = 8'h00;
            endcase
         end
         default: begin
            case (idx)
               3'd0: c = "s";
               3'd1: c = "a";
               3'd2: c = "v";
               3'd3: c = "e";
               3'd4: c = "_";
               default: c = 8'h00;
            endcase
         end
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

### sv/ctt_if.sv
// Handshake channel interfaces for the tokenizer's text input and token output.
`timescale 1ns / 1ps
`default_nettype none

interface ctt_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] data_byte;

   modport source (output valid, output command, output data_byte, input ready);
   modport sink (input valid, input command, input data_byte, output ready);
endinterface

interface ctt_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  token_kind;
   logic [31:0] start_offset;
   logic [31:0] content_length;
   logic [31:0] start_line;
   logic [31:0] start_column;
   logic        last_in_run;

   modport source (output valid, output token_kind, output start_offset,
                   output content_length, output start_line, output start_column,
                   output last_in_run, input ready);
   modport sink (input valid, input token_kind, input start_offset,
                 input content_length, input start_line, input start_column,
                 input last_in_run, output ready);
endinterface

`default_nettype wire

### sv/ctt_lexer.sv
// Lexer state and the single-pass step logic that turns one beat into up to two tokens.
`timescale 1ns / 1ps
`default_nettype none

module ctt_lexer #(
   parameter int POSITION_BITS = 32
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    accept,
   input  wire                    command,
   input  wire [7:0]              data_byte,
   output ctt_pkg::result_type    res0,
   output ctt_pkg::result_type    res1,
   output logic [1:0]             res_count
);

   localparam int P = POSITION_BITS;
   localparam int W = (P > 32) ? P : 32;

   // Saturating add of a small amount.
   function automatic logic [P-1:0] sat_add(input logic [P-1:0] x, input logic [1:0] k);
      logic [P:0] s;
      s = {1'b0, x} + (P+1)'(k);
      return s[P] ? {P{1'b1}} : s[P-1:0];
   endfunction

   // Low 32 bits of a position value.
   function automatic logic [31:0] low32(input logic [P-1:0] x);
      logic [W-1:0] t;
      t = W'(x);
      return t[31:0];
   endfunction

   function automatic ctt_pkg::result_type mk(input logic [3:0] kind, input logic [P-1:0] off,
                                              input logic [P-1:0] len, input logic [P-1:0] line,
                                              input logic [P-1:0] col);
      ctt_pkg::result_type r;
      r.token_kind     = kind;
      r.start_offset   = low32(off);
      r.content_length = low32(len);
      r.start_line     = low32(line);
      r.start_column   = low32(col);
      r.last_in_run    = 1'b0;
      return r;
   endfunction

   function automatic logic is_blank(input logic [7:0] b);
      return (b == " ") || (b == 8'h09) || (b == 8'h0D) || (b == 8'h0A);
   endfunction

   ctt_pkg::mode_type mode_ff, mode_in;
   logic [P-1:0] pos_ff, pos_in, line_ff, line_in, col_ff, col_in;
   logic [P-1:0] tok_off_ff, tok_off_in, tok_row_ff, tok_row_in;
   logic [P-1:0] tok_col_ff, tok_col_in, tok_len_ff, tok_len_in;
   logic [7:0]   delim_ff, delim_in;
   logic [1:0]   run_ff, run_in;
   logic [4:0]   flags_ff, flags_in;
   logic         cr_ff, cr_in;

   ctt_pkg::result_type a_res, b_res;
   logic a_v, b_v;
   logic do_idle, do_flush, do_wstart, do_wfeed, r1;
   logic [7:0] lb;
   logic [3:0] flush_kind;

   // Kind of the word held in the token registers.
   always_comb begin
      flush_kind = ctt_pkg::KIND_VALUE;
      if ((tok_len_ff != '0) && flags_ff[ctt_pkg::FLAG_TAG]) begin
         flush_kind = ctt_pkg::KIND_TAG;
      end else if (flags_ff[ctt_pkg::FLAG_DATA] && (tok_len_ff >= P'(5))) begin
         flush_kind = ctt_pkg::KIND_BLOCK;
      end else if (flags_ff[ctt_pkg::FLAG_GLOBAL] && (tok_len_ff == P'(7))) begin
         flush_kind = ctt_pkg::KIND_BLOCK;
      end else if (flags_ff[ctt_pkg::FLAG_LOOP] && (tok_len_ff == P'(5))) begin
         flush_kind = ctt_pkg::KIND_LOOP;
      end else if (flags_ff[ctt_pkg::FLAG_SAVE] && (tok_len_ff >= P'(5))) begin
         flush_kind = (tok_len_ff == P'(5)) ? ctt_pkg::KIND_SAVE_END
                                            : ctt_pkg::KIND_SAVE_HDR;
      end
   end

   // Next state and emitted tokens for the accepted beat.
   always_comb begin
      mode_in = mode_ff;
      pos_in = pos_ff;
      line_in = line_ff;
      col_in = col_ff;
      tok_off_in = tok_off_ff;
      tok_row_in = tok_row_ff;
      tok_col_in = tok_col_ff;
      tok_len_in = tok_len_ff;
      delim_in = delim_ff;
      run_in = run_ff;
      flags_in = flags_ff;
      cr_in = cr_ff;
      a_v = 1'b0;
      b_v = 1'b0;
      a_res = mk(ctt_pkg::KIND_VALUE, tok_off_ff, tok_len_ff, tok_row_ff, tok_col_ff);
      b_res = mk(ctt_pkg::KIND_EOF, pos_ff, '0, line_ff, col_ff);
      do_idle = 1'b0;
      do_flush = 1'b0;
      do_wstart = 1'b0;
      do_wfeed = 1'b0;
      r1 = 1'b0;
      lb = (data_byte inside {["A":"Z"]}) ? data_byte + 8'd32 : data_byte;

      if (accept && (command == ctt_pkg::CMD_END)) begin
         // End marker: flush what is pending, then end of file or error; none if done.
         case (mode_ff)
            ctt_pkg::MODE_BOM1, ctt_pkg::MODE_BOM2, ctt_pkg::MODE_WORD: begin
               a_v = 1'b1;
               a_res.token_kind = flush_kind;
               b_v = 1'b1;
            end
            ctt_pkg::MODE_Q1: begin
               a_v = 1'b1;
               a_res.token_kind = ctt_pkg::KIND_QERR;
            end
            ctt_pkg::MODE_Q2: begin
               a_v = 1'b1;
               a_res.content_length = '0;
               b_v = 1'b1;
            end
            ctt_pkg::MODE_QUOTED: begin
               a_v = 1'b1;
               if (run_ff == 2'd1) begin
                  b_v = 1'b1;
               end else begin
                  a_res.token_kind = ctt_pkg::KIND_QERR;
               end
            end
            ctt_pkg::MODE_TRIPLE: begin
               a_v = 1'b1;
               a_res.content_length = low32(sat_add(tok_len_ff, run_ff));
               b_v = 1'b1;
            end
            ctt_pkg::MODE_FIELD: begin
               a_v = 1'b1;
               a_res.token_kind = ctt_pkg::KIND_FERR;
            end
            ctt_pkg::MODE_DONE: begin
               a_v = 1'b0;
            end
            default: begin
               b_v = 1'b1;
            end
         endcase
         mode_in = ctt_pkg::MODE_BOM0;
         pos_in = '0;
         line_in = P'(1);
         col_in = P'(1);
         tok_off_in = '0;
         tok_row_in = P'(1);
         tok_col_in = P'(1);
         tok_len_in = '0;
         delim_in = 8'h00;
         run_in = 2'd0;
         flags_in = 5'h1F;
         cr_in = 1'b0;
      end else if (accept) begin
         // Mode-specific handling of one text byte.
         case (mode_ff)
            ctt_pkg::MODE_BOM0: begin
               if (data_byte == ctt_pkg::BYTE_BOM0) begin
                  do_wstart = 1'b1;
                  do_wfeed = 1'b1;
                  mode_in = ctt_pkg::MODE_BOM1;
               end else begin
                  do_idle = 1'b1;
               end
            end
            ctt_pkg::MODE_BOM1, ctt_pkg::MODE_BOM2, ctt_pkg::MODE_WORD: begin
               if ((mode_ff == ctt_pkg::MODE_BOM1) && (data_byte == ctt_pkg::BYTE_BOM1)) begin
                  do_wfeed = 1'b1;
                  mode_in = ctt_pkg::MODE_BOM2;
               end else if ((mode_ff == ctt_pkg::MODE_BOM2) &&
                            (data_byte == ctt_pkg::BYTE_BOM2)) begin
                  mode_in = ctt_pkg::MODE_IDLE;
               end else if (is_blank(data_byte) || (data_byte == 8'h00)) begin
                  do_flush = 1'b1;
                  do_idle = 1'b1;
               end else begin
                  mode_in = ctt_pkg::MODE_WORD;
                  do_wfeed = 1'b1;
               end
            end
            ctt_pkg::MODE_COMMENT: begin
               if ((data_byte == 8'h0D) || (data_byte == 8'h0A)) begin
                  do_idle = 1'b1;
               end
            end
            ctt_pkg::MODE_Q1, ctt_pkg::MODE_Q2, ctt_pkg::MODE_QUOTED: begin
               if ((mode_ff != ctt_pkg::MODE_QUOTED) && (data_byte == delim_ff)) begin
                  if (mode_ff == ctt_pkg::MODE_Q1) begin
                     mode_in = ctt_pkg::MODE_Q2;
                  end else begin
                     mode_in = ctt_pkg::MODE_TRIPLE;
                     tok_off_in = sat_add(tok_off_ff, 2'd2);
                     tok_len_in = '0;
                     run_in = 2'd0;
                  end
               end else begin
                  // Quoted string body; a quote closes only before a blank or NUL.
                  mode_in = ctt_pkg::MODE_QUOTED;
                  if (mode_ff == ctt_pkg::MODE_Q2) begin
                     r1 = 1'b1;
                  end else if (mode_ff == ctt_pkg::MODE_QUOTED) begin
                     r1 = (run_ff == 2'd1);
                  end
                  if (r1 && (is_blank(data_byte) || (data_byte == 8'h00))) begin
                     a_v = 1'b1;
                     run_in = 2'd0;
                     do_idle = 1'b1;
                  end else begin
                     tok_len_in = sat_add(tok_len_ff,
                                          {1'b0, r1} + {1'b0, data_byte != delim_ff});
                     run_in = (data_byte == delim_ff) ? 2'd1 : 2'd0;
                  end
               end
            end
            ctt_pkg::MODE_TRIPLE: begin
               if (data_byte == delim_ff) begin
                  if (run_ff >= 2'd2) begin
                     a_v = 1'b1;
                     run_in = 2'd0;
                     mode_in = ctt_pkg::MODE_IDLE;
                  end else begin
                     run_in = run_ff + 2'd1;
                  end
               end else begin
                  tok_len_in = sat_add(tok_len_ff, run_ff + 2'd1);
                  run_in = 2'd0;
               end
            end
            ctt_pkg::MODE_FIELD: begin
               if ((data_byte == ";") && (col_ff == P'(1))) begin
                  a_v = 1'b1;
                  mode_in = ctt_pkg::MODE_IDLE;
               end else begin
                  tok_len_in = sat_add(tok_len_ff, 2'd1);
               end
            end
            ctt_pkg::MODE_DONE: begin
               mode_in = ctt_pkg::MODE_DONE;
            end
            default: begin
               do_idle = 1'b1;
            end
         endcase

         if (do_flush) begin
            a_v = 1'b1;
            a_res.token_kind = flush_kind;
         end

         // Token start decision.
         if (do_idle) begin
            mode_in = ctt_pkg::MODE_IDLE;
            if (data_byte == "#") begin
               mode_in = ctt_pkg::MODE_COMMENT;
            end else if (is_blank(data_byte)) begin
               mode_in = ctt_pkg::MODE_IDLE;
            end else if (data_byte == ctt_pkg::BYTE_EOF) begin
               b_v = 1'b1;
               mode_in = ctt_pkg::MODE_DONE;
            end else if (data_byte == 8'h00) begin
               b_v = 1'b1;
               b_res.token_kind = ctt_pkg::KIND_VALUE;
            end else if ((data_byte == ";") && (col_ff == P'(1))) begin
               mode_in = ctt_pkg::MODE_FIELD;
               tok_off_in = sat_add(pos_ff, 2'd1);
               tok_row_in = line_ff;
               tok_col_in = col_ff;
               tok_len_in = '0;
            end else if ((data_byte == 8'h27) || (data_byte == 8'h22)) begin
               mode_in = ctt_pkg::MODE_Q1;
               delim_in = data_byte;
               tok_off_in = sat_add(pos_ff, 2'd1);
               tok_row_in = line_ff;
               tok_col_in = col_ff;
               tok_len_in = '0;
               run_in = 2'd0;
            end else begin
               mode_in = ctt_pkg::MODE_WORD;
               do_wstart = 1'b1;
               do_wfeed = 1'b1;
            end
         end

         if (do_wstart) begin
            tok_off_in = pos_ff;
            tok_row_in = line_ff;
            tok_col_in = col_ff;
            tok_len_in = '0;
            flags_in = 5'h1F;
         end

         // Keyword matching on the word's next character.
         if (do_wfeed) begin
            if ((tok_len_in == '0) && (data_byte != "_")) begin
               flags_in[ctt_pkg::FLAG_TAG] = 1'b0;
            end
            if (tok_len_in < P'(5)) begin
               if (lb != ctt_pkg::kw_char(ctt_pkg::KW_DATA, tok_len_in[2:0])) begin
                  flags_in[ctt_pkg::FLAG_DATA] = 1'b0;
               end
               if (lb != ctt_pkg::kw_char(ctt_pkg::KW_LOOP, tok_len_in[2:0])) begin
                  flags_in[ctt_pkg::FLAG_LOOP] = 1'b0;
               end
               if (lb != ctt_pkg::kw_char(ctt_pkg::KW_SAVE, tok_len_in[2:0])) begin
                  flags_in[ctt_pkg::FLAG_SAVE] = 1'b0;
               end
            end else begin
               flags_in[ctt_pkg::FLAG_LOOP] = 1'b0;
            end
            if (tok_len_in < P'(7)) begin
               if (lb != ctt_pkg::kw_char(ctt_pkg::KW_GLOBAL, tok_len_in[2:0])) begin
                  flags_in[ctt_pkg::FLAG_GLOBAL] = 1'b0;
               end
            end else begin
               flags_in[ctt_pkg::FLAG_GLOBAL] = 1'b0;
            end
            tok_len_in = sat_add(tok_len_in, 2'd1);
         end

         // Position, line and column of the next byte.
         if (mode_ff != ctt_pkg::MODE_DONE) begin
            pos_in = sat_add(pos_ff, 2'd1);
            if (data_byte == 8'h0D) begin
               line_in = sat_add(line_ff, 2'd1);
               col_in = P'(1);
               cr_in = 1'b1;
            end else if (data_byte == 8'h0A) begin
               if (!cr_ff) begin
                  line_in = sat_add(line_ff, 2'd1);
               end
               col_in = P'(1);
               cr_in = 1'b0;
            end else begin
               col_in = sat_add(col_ff, 2'd1);
               cr_in = 1'b0;
            end
         end
      end
   end

   // Pack the emitted tokens in order and mark the last one.
   always_comb begin
      res0 = a_v ? a_res : b_res;
      res1 = b_res;
      res_count = {1'b0, a_v} + {1'b0, b_v};
      res0.last_in_run = (res_count == 2'd1);
      res1.last_in_run = 1'b1;
   end

   // Lexer state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ctt_pkg::MODE_BOM0;
         pos_ff <= '0;
         line_ff <= P'(1);
         col_ff <= P'(1);
         tok_off_ff <= '0;
         tok_row_ff <= P'(1);
         tok_col_ff <= P'(1);
         tok_len_ff <= '0;
         delim_ff <= 8'h00;
         run_ff <= 2'd0;
         flags_ff <= 5'h1F;
         cr_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         pos_ff <= pos_in;
         line_ff <= line_in;
         col_ff <= col_in;
         tok_off_ff <= tok_off_in;
         tok_row_ff <= tok_row_in;
         tok_col_ff <= tok_col_in;
         tok_len_ff <= tok_len_in;
         delim_ff <= delim_in;
         run_ff <= run_in;
         flags_ff <= flags_in;
         cr_ff <= cr_in;
      end
   end

endmodule

`default_nettype wire

### sv/ctt_out_queue.sv
// Two-slot token output stage: an output register and a spill register.
`timescale 1ns / 1ps
`default_nettype none

module ctt_out_queue (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push,
   input  wire [1:0]             push_count,
   input  ctt_pkg::result_type   push0,
   input  ctt_pkg::result_type   push1,
   output logic                  can_push,
   output logic                  out_valid,
   input  wire                   out_ready,
   output ctt_pkg::result_type   out_data
);

   ctt_pkg::result_type head_ff, head_in, spill_ff, spill_in;
   logic head_v_ff, head_v_in, spill_v_ff, spill_v_in;
   logic pop;

   assign pop = head_v_ff && out_ready;
   // A beat may enter when both slots will be free after this cycle's pop.
   assign can_push = !spill_v_ff && (!head_v_ff || out_ready);
   assign out_valid = head_v_ff;
   assign out_data = head_ff;

   // Slot update: new tokens land in empty slots, otherwise the spill moves up.
   always_comb begin
      head_in = head_ff;
      spill_in = spill_ff;
      head_v_in = head_v_ff;
      spill_v_in = spill_v_ff;
      if (push) begin
         head_in = push0;
         spill_in = push1;
         head_v_in = (push_count != 2'd0);
         spill_v_in = (push_count == 2'd2);
      end else if (pop) begin
         head_in = spill_ff;
         head_v_in = spill_v_ff;
         spill_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_v_ff <= 1'b0;
         spill_v_ff <= 1'b0;
      end else begin
         head_v_ff <= head_v_in;
         spill_v_ff <= spill_v_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      spill_ff <= spill_in;
   end

endmodule

`default_nettype wire

### sv/cif_text_tokenizer_core.sv
// Top level of the CIF text tokenizer: lexer plus token output stage.
// A token appears on the output in the cycle after the beat that completes it.
// Throughput: one byte per cycle unless the output stalls; a beat with two tokens
// (a word or quote closed by NUL, or a flush plus end of file) holds the input.
// Reset: synchronous, active high; returns to document start and empties the output.
// Every end-of-document beat also returns the lexer to document start.
`timescale 1ns / 1ps
`default_nettype none

module cif_text_tokenizer_core #(
   parameter int POSITION_BITS = 32
) (
   input  wire        clock,
   input  wire        reset,
   ctt_req_if.sink    req_chan,
   ctt_rsp_if.source  rsp_chan
);

   ctt_pkg::result_type res0, res1, out_data;
   logic [1:0] res_count;
   logic accept, can_push, out_valid;

   assign req_chan.ready = can_push;
   assign accept = req_chan.valid && can_push;

   ctt_lexer #(.POSITION_BITS(POSITION_BITS)) u_lexer (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .command   (req_chan.command),
      .data_byte (req_chan.data_byte),
      .res0      (res0),
      .res1      (res1),
      .res_count (res_count)
   );

   ctt_out_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_count (res_count),
      .push0      (res0),
      .push1      (res1),
      .can_push   (can_push),
      .out_valid  (out_valid),
      .out_ready  (rsp_chan.ready),
      .out_data   (out_data)
   );

   assign rsp_chan.valid = out_valid;
   assign rsp_chan.token_kind = out_data.token_kind;
   assign rsp_chan.start_offset = out_data.start_offset;
   assign rsp_chan.content_length = out_data.content_length;
   assign rsp_chan.start_line = out_data.start_line;
   assign rsp_chan.start_column = out_data.start_column;
   assign rsp_chan.last_in_run = out_data.last_in_run;

endmodule

`default_nettype wire

### sv/ctt_checker.sv
// Port-level checks of the tokenizer and their attachment to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ctt_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [3:0]  token_kind,
   input wire [31:0] content_length,
   input wire [31:0] start_line,
   input wire        last_in_run
);

   // A stalled beat stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("token beat withdrawn while stalled");

   // Kinds stay within the defined set.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> token_kind <= ctt_pkg::KIND_FERR)
      else $error("token kind out of range");

   // End of file carries no content and always closes a run.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && token_kind == ctt_pkg::KIND_EOF |-> content_length == 32'd0 && last_in_run)
      else $error("end of file with content or not last");

   // Errors end a document, so they close their run.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (token_kind == ctt_pkg::KIND_QERR || token_kind == ctt_pkg::KIND_FERR)
      |-> last_in_run)
      else $error("error token not last in run");

   // Line numbers start at one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> start_line != 32'd0)
      else $error("zero line number");

endmodule

bind cif_text_tokenizer_core ctt_checker u_ctt_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .token_kind     (rsp_chan.token_kind),
   .content_length (rsp_chan.content_length),
   .start_line     (rsp_chan.start_line),
   .last_in_run    (rsp_chan.last_in_run)
);

`default_nettype wire
